FILE: rtl/core/smv_pkg.sv
// Package for the SysEx message validator: status and kind codes, register
// indexes, protocol bytes and register reset values.
// No dependencies.
`default_nettype none

package smv_pkg;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_FRAMING  = 4'd1,
      ST_MAKER    = 4'd2,
      ST_SHORT    = 4'd3,
      ST_ID_SHORT = 4'd4,
      ST_FOREIGN  = 4'd5,
      ST_UNKNOWN  = 4'd6,
      ST_LENGTH   = 4'd7,
      ST_CHECKSUM = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      KIND_PATCH    = 2'd0,
      KIND_MASTER   = 2'd1,
      KIND_SPLIT    = 2'd2,
      KIND_ID_REPLY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_MIN_LENGTH    = 3'd0,
      REG_PATCH_OPCODE  = 3'd1,
      REG_MASTER_OPCODE = 3'd2,
      REG_SPLIT_OPCODE  = 3'd3,
      REG_PATCH_LENGTH  = 3'd4,
      REG_MASTER_LENGTH = 3'd5,
      REG_SPLIT_LENGTH  = 3'd6
   } reg_index_type;

   localparam int LEN_REG_W  = 10;
   localparam int OPC_REG_W  = 7;
   localparam int CSR_DATA_W = 10;

   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] SYSEX_END    = 8'hF7;
   localparam logic [7:0] UNIVERSAL_ID = 8'h7E;
   localparam logic [7:0] MAKER_ID     = 8'h10;
   localparam logic [7:0] DEVICE_ID    = 8'h06;
   localparam logic [7:0] ID_SUB1      = 8'h06;
   localparam logic [7:0] ID_SUB2      = 8'h02;
   localparam logic [3:0] NIBBLE_MASK  = 4'hF;

   localparam int HEADER_DEPTH = 5;
   // Byte index at which the first nibble byte leaves the two-byte delay line.
   localparam int NIBBLE_START = 7;
   localparam int MIN_HEADER_LEN = 4;
   localparam int ID_MIN_LEN = 15;
   // Shortest length that leaves at least one nibble byte before the checksum.
   localparam int MIN_BODY_LEN = 8;

   localparam logic [LEN_REG_W-1:0] RST_MIN_LENGTH    = 10'd6;
   localparam logic [OPC_REG_W-1:0] RST_PATCH_OPCODE  = 7'd1;
   localparam logic [OPC_REG_W-1:0] RST_MASTER_OPCODE = 7'd3;
   localparam logic [OPC_REG_W-1:0] RST_SPLIT_OPCODE  = 7'd2;
   localparam logic [LEN_REG_W-1:0] RST_PATCH_LENGTH  = 10'd275;
   localparam logic [LEN_REG_W-1:0] RST_MASTER_LENGTH = 10'd351;
   localparam logic [LEN_REG_W-1:0] RST_SPLIT_LENGTH  = 10'd41;

endpackage

`default_nettype wire

FILE: rtl/core/sysex_message_validator.sv
// Top level of the SysEx message validator: input register, running message
// state, verdict logic and result register. Depends on smv_pkg.
`default_nettype none

// Checks one MIDI system-exclusive message per run of bytes, the last byte
// marked by req_last_byte, and gives one status and kind transaction on that
// last byte only. One byte is accepted every cycle while req_stall is low; a
// byte is held in the input register, and a last byte's verdict is then loaded
// into the result register, which drives rsp_valid.
// The input side stalls only when a last byte waits in the input register
// while the result register still holds an untaken result. Configuration
// writes take effect at once and are meant for times when no message is
// in flight. The byte counter is COUNT_BITS wide and saturates.
module sysex_message_validator
   import smv_pkg::*;
#(
   parameter int COUNT_BITS = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [7:0]            req_data_byte,
   input  wire                   req_last_byte,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [3:0]            rsp_status,
   output logic [1:0]            rsp_message_kind,
   input  wire                   csr_write_enable,
   input  wire  [2:0]            csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   localparam int LEN_W = (COUNT_BITS > LEN_REG_W) ? COUNT_BITS : LEN_REG_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Configuration registers.
   logic [LEN_REG_W-1:0] min_length_ff, patch_length_ff, master_length_ff, split_length_ff;
   logic [OPC_REG_W-1:0] patch_opcode_ff, master_opcode_ff, split_opcode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff    <= RST_MIN_LENGTH;
         patch_opcode_ff  <= RST_PATCH_OPCODE;
         master_opcode_ff <= RST_MASTER_OPCODE;
         split_opcode_ff  <= RST_SPLIT_OPCODE;
         patch_length_ff  <= RST_PATCH_LENGTH;
         master_length_ff <= RST_MASTER_LENGTH;
         split_length_ff  <= RST_SPLIT_LENGTH;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_MIN_LENGTH:    min_length_ff    <= csr_data;
            REG_PATCH_OPCODE:  patch_opcode_ff  <= csr_data[OPC_REG_W-1:0];
            REG_MASTER_OPCODE: master_opcode_ff <= csr_data[OPC_REG_W-1:0];
            REG_SPLIT_OPCODE:  split_opcode_ff  <= csr_data[OPC_REG_W-1:0];
            REG_PATCH_LENGTH:  patch_length_ff  <= csr_data;
            REG_MASTER_LENGTH: master_length_ff <= csr_data;
            REG_SPLIT_LENGTH:  split_length_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       req_accept, out_free, process;

   assign out_free   = !rsp_valid || !rsp_stall;
   assign process    = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall  = in_valid_ff && !process;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Running message state.
   logic [COUNT_BITS-1:0] count_ff, count_in, len;
   logic [7:0]            header_ff [HEADER_DEPTH];
   logic [7:0]            sum_ff, sum_in;
   logic [3:0]            held_ff, held_in;
   logic                  phase_ff, phase_in;
   logic [7:0]            delay0_ff, delay1_ff;
   logic                  take_nibble;

   assign len         = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : COUNT_MAX;
   assign take_nibble = count_ff >= COUNT_BITS'(NIBBLE_START);

   always_comb begin
      sum_in   = sum_ff;
      held_in  = held_ff;
      phase_in = phase_ff;
      if (take_nibble) begin
         if (!phase_ff) begin
            held_in  = delay0_ff[3:0] & NIBBLE_MASK;
            phase_in = 1'b1;
         end else begin
            sum_in   = sum_ff + {delay0_ff[3:0], held_ff};
            phase_in = 1'b0;
         end
      end
      count_in = len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         held_ff   <= '0;
         phase_ff  <= 1'b0;
         delay0_ff <= '0;
         delay1_ff <= '0;
      end else if (process) begin
         if (in_last_ff) begin
            count_ff  <= '0;
            sum_ff    <= '0;
            held_ff   <= '0;
            phase_ff  <= 1'b0;
            delay0_ff <= '0;
            delay1_ff <= '0;
         end else begin
            count_ff  <= count_in;
            sum_ff    <= sum_in;
            held_ff   <= held_in;
            phase_ff  <= phase_in;
            delay0_ff <= delay1_ff;
            delay1_ff <= in_byte_ff;
         end
      end
   end

   // Header bytes are only read at positions already written in this message.
   always_ff @(posedge clock) begin
      if (process) begin
         for (int i = 0; i < HEADER_DEPTH; i++) begin
            if (count_ff == COUNT_BITS'(i)) begin
               header_ff[i] <= in_byte_ff;
            end
         end
      end
   end

   // Verdict on the current byte, as if it were the last one.
   logic [7:0]       hdr_val  [HEADER_DEPTH];
   logic             hdr_here [HEADER_DEPTH];
   logic [LEN_W-1:0] len_ext, want;
   logic             h0_start, h1_univ, maker_ok, id_reply, op_hit, sum_ok;
   kind_type         op_kind, kind;
   status_type       status;

   always_comb begin
      for (int i = 0; i < HEADER_DEPTH; i++) begin
         hdr_here[i] = count_ff >= COUNT_BITS'(i);
         hdr_val[i]  = (count_ff == COUNT_BITS'(i)) ? in_byte_ff : header_ff[i];
      end
   end

   assign len_ext  = LEN_W'(len);
   assign h0_start = hdr_val[0] == SYSEX_START;
   assign h1_univ  = hdr_here[1] && hdr_val[1] == UNIVERSAL_ID;
   assign maker_ok = hdr_here[1] && hdr_val[1] == MAKER_ID
                     && hdr_here[2] && hdr_val[2] == DEVICE_ID;
   assign id_reply = h1_univ && hdr_here[3] && hdr_val[3] == ID_SUB1
                     && hdr_here[4] && hdr_val[4] == ID_SUB2;
   assign sum_ok   = {1'b0, sum_in[6:0]} == delay1_ff;

   always_comb begin
      op_hit  = 1'b1;
      op_kind = KIND_PATCH;
      want    = '0;
      priority if (hdr_val[3] == {1'b0, patch_opcode_ff}) begin
         want    = LEN_W'(patch_length_ff);
         op_kind = KIND_PATCH;
      end else if (hdr_val[3] == {1'b0, master_opcode_ff}) begin
         want    = LEN_W'(master_length_ff);
         op_kind = KIND_MASTER;
      end else if (hdr_val[3] == {1'b0, split_opcode_ff}) begin
         want    = LEN_W'(split_length_ff);
         op_kind = KIND_SPLIT;
      end else begin
         op_hit = 1'b0;
      end
   end

   always_comb begin
      status = ST_OK;
      kind   = KIND_PATCH;
      priority if (len_ext < LEN_W'(min_length_ff) || !h0_start || in_byte_ff != SYSEX_END) begin
         status = ST_FRAMING;
      end else if (len_ext < LEN_W'(MIN_HEADER_LEN)) begin
         status = ST_MAKER;
      end else if (!h1_univ && !maker_ok) begin
         status = ST_MAKER;
      end else if (id_reply) begin
         if (len_ext < LEN_W'(ID_MIN_LEN)) begin
            status = ST_ID_SHORT;
         end else begin
            kind = KIND_ID_REPLY;
         end
      end else if (!maker_ok) begin
         status = ST_FOREIGN;
      end else if (!op_hit) begin
         status = ST_UNKNOWN;
      end else if (len_ext != want) begin
         status = ST_LENGTH;
      end else if (len_ext < LEN_W'(MIN_BODY_LEN) || !len[0] || !sum_ok) begin
         // The nibble count is the length minus seven and must be even.
         status = ST_CHECKSUM;
      end else begin
         kind = op_kind;
      end
   end

   // Result register.
   logic       rsp_valid_ff;
   logic [3:0] rsp_status_ff;
   logic [1:0] rsp_kind_ff;
   logic       rsp_load;

   assign rsp_load = process && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status;
         rsp_kind_ff   <= kind;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_message_kind = rsp_kind_ff;

endmodule

`default_nettype wire

FILE: rtl/core/smv_checker.sv
// Port-level checker for the SysEx message validator, bound to its top level.
// Depends on smv_pkg and sysex_message_validator.
`default_nettype none

module smv_checker
   import smv_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [3:0] rsp_status,
   input wire [1:0] rsp_message_kind
);

   // A held result transaction keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_message_kind))
      else $error("result changed while stalled");

   // Only a passing message carries a kind.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_message_kind == KIND_PATCH)
      else $error("kind set on a failing message");

   // The short status is answered earlier by the maker check; codes stop at checksum.
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != ST_SHORT && rsp_status <= ST_CHECKSUM)
      else $error("status code out of range");

   // Nothing in flight survives reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sysex_message_validator smv_checker u_smv_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_message_kind (rsp_message_kind)
);

`default_nettype wire
